>>> rtl/binary_to_roman_numeral_unit_macros.svh
// assertion macros shared by the checker
`ifndef BINARY_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH
`define BINARY_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define B2R_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define B2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/b2r_pkg.sv
package b2r_pkg;

    // widths
    localparam int VALUE_W  = 16;
    localparam int REST_W   = 12;
    localparam int IDX_W    = 4;
    localparam int LETTER_W = 8;

    // largest value that has a numeral
    localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3999;

    // ascii codes of the numeral letters
    localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;
    localparam logic [LETTER_W-1:0] CH_M    = 8'h4D;
    localparam logic [LETTER_W-1:0] CH_D    = 8'h44;
    localparam logic [LETTER_W-1:0] CH_C    = 8'h43;
    localparam logic [LETTER_W-1:0] CH_L    = 8'h4C;
    localparam logic [LETTER_W-1:0] CH_X    = 8'h58;
    localparam logic [LETTER_W-1:0] CH_V    = 8'h56;
    localparam logic [LETTER_W-1:0] CH_I    = 8'h49;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_PAIR = 4'b0100,
        ST_ERR  = 4'b1000
    } state_t;

    // one symbol of the numeral table
    typedef struct packed {
        logic [REST_W-1:0]   amount;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                pair;
    } sym_t;

    // result of one compare and subtract step
    typedef struct packed {
        logic                ge;
        logic [REST_W-1:0]   diff;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                pair;
    } step_res_t;

    // symbol table, largest amount first
    function automatic sym_t sym_lookup(input logic [IDX_W-1:0] idx);
        sym_t s;
        case (idx)
            4'd0:    s = '{amount: 12'd1000, first: CH_M, second: CH_NONE, pair: 1'b0};
            4'd1:    s = '{amount: 12'd900,  first: CH_C, second: CH_M,    pair: 1'b1};
            4'd2:    s = '{amount: 12'd500,  first: CH_D, second: CH_NONE, pair: 1'b0};
            4'd3:    s = '{amount: 12'd400,  first: CH_C, second: CH_D,    pair: 1'b1};
            4'd4:    s = '{amount: 12'd100,  first: CH_C, second: CH_NONE, pair: 1'b0};
            4'd5:    s = '{amount: 12'd90,   first: CH_X, second: CH_C,    pair: 1'b1};
            4'd6:    s = '{amount: 12'd50,   first: CH_L, second: CH_NONE, pair: 1'b0};
            4'd7:    s = '{amount: 12'd40,   first: CH_X, second: CH_L,    pair: 1'b1};
            4'd8:    s = '{amount: 12'd10,   first: CH_X, second: CH_NONE, pair: 1'b0};
            4'd9:    s = '{amount: 12'd9,    first: CH_I, second: CH_X,    pair: 1'b1};
            4'd10:   s = '{amount: 12'd5,    first: CH_V, second: CH_NONE, pair: 1'b0};
            4'd11:   s = '{amount: 12'd4,    first: CH_I, second: CH_V,    pair: 1'b1};
            4'd12:   s = '{amount: 12'd1,    first: CH_I, second: CH_NONE, pair: 1'b0};
            default: s = '{amount: 12'd1,    first: CH_I, second: CH_NONE, pair: 1'b0};
        endcase
        return s;
    endfunction

endpackage

>>> rtl/binary_to_roman_numeral_unit.sv
// channel  | ports                        | handshake
// ---------+------------------------------+------------------------------------
// input    | value                        | taken when start is high, busy low
// result   | letter, last, error          | one cycle each, marked by strobe
//
// each table step is one compare and subtract on the shared step unit:
// busy stays high while each letter is emitted and each table entry passed
// over, so 3888 keeps busy high the longest of all in-range values.
// an out-of-range value keeps busy high for one cycle and gives one result.
// each result is registered and appears in the cycle after the step that makes it.
// reset clears the sequencer and the strobe; the receiver cannot stall.
module binary_to_roman_numeral_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [b2r_pkg::VALUE_W-1:0]     value,
    output logic                            busy,
    output logic                            strobe,
    output logic [b2r_pkg::LETTER_W-1:0]    letter,
    output logic                            last,
    output logic                            error
);

    b2r_pkg::state_t                 state_reg, state_next;
    logic [b2r_pkg::REST_W-1:0]      rest_reg, rest_next;
    logic [b2r_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                            strobe_reg, strobe_next;
    logic [b2r_pkg::LETTER_W-1:0]    letter_reg, letter_next;
    logic                            last_reg, last_next;
    logic                            error_reg, error_next;
    logic                            value_bad;
    b2r_pkg::step_res_t              step_res;

    // shared compare and subtract unit
    b2r_step_unit u_step (
        .rest (rest_reg),
        .idx  (idx_reg),
        .res  (step_res)
    );

    // range check on the incoming value
    assign value_bad = (value == '0) || (value > b2r_pkg::MAX_VALUE);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        rest_next   = rest_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        letter_next = letter_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        case (state_reg)
            b2r_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    rest_next  = value[b2r_pkg::REST_W-1:0];
                    idx_next   = '0;
                    state_next = value_bad ? b2r_pkg::ST_ERR : b2r_pkg::ST_RUN;
                end
            end
            b2r_pkg::ST_RUN:
            begin
                if (step_res.ge)
                begin
                    rest_next   = step_res.diff;
                    strobe_next = 1'b1;
                    letter_next = step_res.first;
                    error_next  = 1'b0;
                    if (step_res.pair)
                    begin
                        last_next  = 1'b0;
                        state_next = b2r_pkg::ST_PAIR;
                    end
                    else
                    begin
                        last_next = (step_res.diff == '0);
                        if (step_res.diff == '0)
                        begin
                            state_next = b2r_pkg::ST_IDLE;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            b2r_pkg::ST_PAIR:
            begin
                // second letter of a subtractive pair, rest already reduced
                strobe_next = 1'b1;
                letter_next = step_res.second;
                error_next  = 1'b0;
                last_next   = (rest_reg == '0);
                state_next  = (rest_reg == '0) ? b2r_pkg::ST_IDLE : b2r_pkg::ST_RUN;
            end
            b2r_pkg::ST_ERR:
            begin
                strobe_next = 1'b1;
                letter_next = b2r_pkg::CH_NONE;
                last_next   = 1'b1;
                error_next  = 1'b1;
                state_next  = b2r_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = b2r_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= b2r_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        idx_reg    <= idx_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    // outputs
    assign busy   = (state_reg != b2r_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign letter = letter_reg;
    assign last   = last_reg;
    assign error  = error_reg;

endmodule

>>> rtl/b2r_step_unit.sv
module b2r_step_unit (
    input  logic [b2r_pkg::REST_W-1:0] rest,
    input  logic [b2r_pkg::IDX_W-1:0]  idx,
    output b2r_pkg::step_res_t         res
);

    b2r_pkg::sym_t sym;

    // table lookup for the current symbol
    assign sym = b2r_pkg::sym_lookup(idx);

    // shared compare and subtract
    always_comb
    begin
        res.ge     = (rest >= sym.amount);
        res.diff   = rest - sym.amount;
        res.first  = sym.first;
        res.second = sym.second;
        res.pair   = sym.pair;
    end

endmodule

>>> rtl/b2r_checker.sv
`include "binary_to_roman_numeral_unit_macros.svh"

module b2r_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic [b2r_pkg::VALUE_W-1:0]     value,
    input logic                            busy,
    input logic                            strobe,
    input logic [b2r_pkg::LETTER_W-1:0]    letter,
    input logic                            last,
    input logic                            error
);

    logic letter_known;
    logic take_bad;

    // letter is one of the numeral letters
    assign letter_known = (letter == b2r_pkg::CH_M) || (letter == b2r_pkg::CH_D) ||
                          (letter == b2r_pkg::CH_C) || (letter == b2r_pkg::CH_L) ||
                          (letter == b2r_pkg::CH_X) || (letter == b2r_pkg::CH_V) ||
                          (letter == b2r_pkg::CH_I);

    // out-of-range item taken this cycle
    assign take_bad = start && !busy && ((value == '0) || (value > b2r_pkg::MAX_VALUE));

    // an error result is a lone zero letter
    `B2R_ASSERT_SAME(a_err_form, strobe && error, last && (letter == b2r_pkg::CH_NONE), "bad error result")

    // a good result carries a numeral letter
    `B2R_ASSERT_SAME(a_letter_ok, strobe && !error, letter_known, "letter out of set")

    // an accepted item always occupies the block
    `B2R_ASSERT_NEXT(a_take_busy, start && !busy, busy, "not busy after item taken")

    // the final letter shows only once the block is free again
    `B2R_ASSERT_SAME(a_last_free, strobe && last, !busy, "busy at final letter")

    // out-of-range value gives an error result, from the ERR state through the result registers
    `B2R_ASSERT_NEXT(a_range_err, take_bad, ##1 (strobe && error), "missing error result")

endmodule

bind binary_to_roman_numeral_unit b2r_checker u_b2r_checker (.*);
